// ===== rtl/core/fsnt_pkg.sv =====
// fsnt_pkg: shared types and constants of the flow sequence number table
// used by every module under rtl/core but fsnt_ram; depends on nothing
`default_nettype none

package fsnt_pkg;

	// table geometry
	localparam int NUM_SETS = 2048;
	localparam int NUM_WAYS = 4;
	localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	// front-to-back queue, power of two deep
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// murmur-style mixing constants
	localparam logic [31:0] HASH_C1 = 32'h9e37_79b9;
	localparam logic [31:0] HASH_C2 = 32'h85eb_ca6b;
	localparam logic [31:0] HASH_C3 = 32'hc2b2_ae35;

	// classified item, front to back
	typedef struct packed {
		logic             is_udp;
		logic [31:0]      src_ip;
		logic [31:0]      dst_ip;
		logic [15:0]      sport;
		logic [15:0]      dport;
		logic [SET_W-1:0] set_idx;
	} item_t;

	// one way of one set as stored in a way ram
	typedef struct packed {
		logic        valid;
		logic [63:0] addr_key;
		logic [31:0] port_key;
		logic [31:0] next_num;
		logic [31:0] recency;
	} entry_t;

	// back status seen by the front
	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fsnt_ram.sv =====
// fsnt_ram: generic single-write, single-read ram with registered read
// no package dependency
`default_nettype none

module fsnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/fsnt_front.sv =====
// fsnt_front: command intake, three-stage key hash and queue credit count
// depends on fsnt_pkg
`default_nettype none

module fsnt_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [31:0]           src_ip,
	input  wire logic [31:0]           dst_ip,
	input  wire logic [15:0]           sport,
	input  wire logic [15:0]           dport,
	input  wire logic                  is_udp,
	input  wire fsnt_pkg::back_status_t bstat,
	output logic                       push,
	output fsnt_pkg::item_t            push_item
);

	logic                        accept;
	logic [fsnt_pkg::QCNT_W-1:0] credits_q;
	logic                        v_s1, v_s2, v_s3;
	fsnt_pkg::item_t             it_s1, it_s2, it_s3;
	logic [31:0]                 h_s1, h_s2, h_s3;
	logic [31:0]                 h_a, h_b, h_c, h_d, h_e;

	assign busy   = bstat.clearing || (credits_q == fsnt_pkg::QCNT_W'(fsnt_pkg::QUEUE_DEPTH));
	assign accept = start && !busy;

	// sa ^ da*c1, fold in ports, xor-shift 16; later stages xor-shift 13 and 16
	always_comb begin
		h_a = src_ip ^ (dst_ip * fsnt_pkg::HASH_C1);
		h_b = h_a ^ {sport, dport};
		h_c = h_b ^ (h_b >> 16);
		h_d = h_s2 ^ (h_s2 >> 13);
		h_e = h_s3 ^ (h_s3 >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept && !bstat.pop) begin
				credits_q <= credits_q + 1'b1;
			end else if (!accept && bstat.pop) begin
				credits_q <= credits_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		it_s1.is_udp  <= is_udp;
		it_s1.src_ip  <= src_ip;
		it_s1.dst_ip  <= dst_ip;
		it_s1.sport   <= sport;
		it_s1.dport   <= dport;
		it_s1.set_idx <= '0;
		h_s1          <= h_c;
		it_s2         <= it_s1;
		h_s2          <= h_s1 * fsnt_pkg::HASH_C2;
		it_s3         <= it_s2;
		h_s3          <= h_d * fsnt_pkg::HASH_C3;
	end

	always_comb begin
		push_item         = it_s3;
		push_item.set_idx = h_e[fsnt_pkg::SET_W-1:0];
	end
	assign push = v_s3;

	// credits cover every item in the hash stages and the queue
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= fsnt_pkg::QCNT_W'(fsnt_pkg::QUEUE_DEPTH))
		else $error("front credit count above queue depth");
	a_pipe_follow: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 push)
		else $error("accepted item did not reach the queue");

endmodule

`default_nettype wire

// ===== rtl/core/fsnt_queue.sv =====
// fsnt_queue: short fifo of classified items between front and back
// depends on fsnt_pkg
`default_nettype none

module fsnt_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fsnt_pkg::item_t push_item,
	input  wire logic            pop,
	output logic                 head_valid,
	output fsnt_pkg::item_t      head_item
);

	fsnt_pkg::item_t             slot_q [fsnt_pkg::QUEUE_DEPTH];
	logic [fsnt_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [fsnt_pkg::QCNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < fsnt_pkg::QCNT_W'(fsnt_pkg::QUEUE_DEPTH))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== rtl/core/fsnt_back.sv =====
// fsnt_back: reset clearing pass, set lookup, hit/victim choice, write-back and result register
// depends on fsnt_pkg and fsnt_ram
`default_nettype none

module fsnt_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire fsnt_pkg::item_t head_item,
	output fsnt_pkg::back_status_t bstat,
	output logic                 done,
	output logic                 ok,
	output logic [31:0]          seq,
	output logic                 new_flow
);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} back_state_t;

	back_state_t                 state_q;
	logic [fsnt_pkg::SET_W-1:0]  clr_addr_q;
	fsnt_pkg::item_t             item_q;
	logic [31:0]                 counter_q;
	logic                        done_q, ok_q, new_flow_q;
	logic [31:0]                 seq_q;

	fsnt_pkg::entry_t            rd [fsnt_pkg::NUM_WAYS];
	fsnt_pkg::entry_t            wr_entry;
	logic [fsnt_pkg::NUM_WAYS-1:0] ram_we;
	logic [fsnt_pkg::SET_W-1:0]  waddr;
	logic                        hit;
	logic [fsnt_pkg::WAY_W-1:0]  hit_way, victim, wr_way;
	logic [31:0]                 stamp;
	logic                        clearing, lookup, pop;

	assign clearing = (state_q == ST_CLEAR);
	assign lookup   = (state_q == ST_LOOKUP);
	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign waddr    = clearing ? clr_addr_q : item_q.set_idx;

	for (genvar w = 0; w < fsnt_pkg::NUM_WAYS; w++) begin : g_way
		fsnt_ram #(
			.WIDTH ($bits(fsnt_pkg::entry_t)),
			.DEPTH (fsnt_pkg::NUM_SETS)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[w]),
			.waddr (waddr),
			.wdata (wr_entry),
			.raddr (head_item.set_idx),
			.rdata (rd[w])
		);
	end

	// hit search, then last invalid way or oldest stamp with lowest way on ties
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		victim  = '0;
		for (int w = 0; w < fsnt_pkg::NUM_WAYS; w++) begin
			if (!hit && rd[w].valid && rd[w].addr_key == {item_q.src_ip, item_q.dst_ip}
					&& rd[w].port_key == {item_q.sport, item_q.dport}) begin
				hit     = 1'b1;
				hit_way = fsnt_pkg::WAY_W'(w);
			end
		end
		for (int w = 0; w < fsnt_pkg::NUM_WAYS; w++) begin
			if (!rd[w].valid) begin
				victim = fsnt_pkg::WAY_W'(w);
			end else if (rd[w].recency < rd[victim].recency) begin
				victim = fsnt_pkg::WAY_W'(w);
			end
		end
		stamp  = counter_q + 32'd1;
		wr_way = hit ? hit_way : victim;

		if (clearing) begin
			wr_entry = '0;
		end else if (hit) begin
			wr_entry          = rd[hit_way];
			wr_entry.next_num = rd[hit_way].next_num + 32'd1;
			wr_entry.recency  = stamp;
		end else begin
			wr_entry.valid    = 1'b1;
			wr_entry.addr_key = {item_q.src_ip, item_q.dst_ip};
			wr_entry.port_key = {item_q.sport, item_q.dport};
			wr_entry.next_num = 32'd1;
			wr_entry.recency  = stamp;
		end

		for (int w = 0; w < fsnt_pkg::NUM_WAYS; w++) begin
			ram_we[w] = clearing || (lookup && (wr_way == fsnt_pkg::WAY_W'(w)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			counter_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == fsnt_pkg::SET_W'(fsnt_pkg::NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						if (head_item.is_udp) begin
							state_q <= ST_LOOKUP;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_LOOKUP: begin
					counter_q <= stamp;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q     <= head_item;
			ok_q       <= 1'b0;
			seq_q      <= '0;
			new_flow_q <= 1'b0;
		end else if (lookup) begin
			ok_q       <= 1'b1;
			seq_q      <= hit ? rd[hit_way].next_num : 32'd0;
			new_flow_q <= !hit;
		end
	end

	assign bstat.clearing = clearing;
	assign bstat.pop      = pop;
	assign done           = done_q;
	assign ok             = ok_q;
	assign seq            = seq_q;
	assign new_flow       = new_flow_q;

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done_q)
		else $error("result strobe during clearing pass");
	a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		lookup |=> state_q == ST_IDLE && done_q)
		else $error("lookup did not finish in one cycle");
	a_single_way_write: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing |-> $onehot0(ram_we))
		else $error("more than one way written");

endmodule

`default_nettype wire

// ===== rtl/core/flow_sequence_number_table_top.sv =====
// flow_sequence_number_table_top: per-flow udp sequence number table
// depends on fsnt_pkg, fsnt_front, fsnt_queue, fsnt_back, fsnt_ram
//
// usage
//   command side: drive the flow key on src_ip/dst_ip/sport/dport/is_udp
//   and raise start; the item is taken at a clock edge with start high and
//   busy low. busy is high while the table clears and while the queue
//   credits are used up.
//   result side: done is high for exactly one cycle per item, in item order,
//   with ok, seq and new_flow valid in that cycle; the receiver cannot stall.
// pipeline
//   the hash takes three stages (one multiplier each), then the item waits
//   in a four-deep queue. the back end reads the set from four way rams
//   (registered read) and writes one way back the next cycle; it pops no
//   new item while a udp item is in lookup, so the ram read / write-back
//   loop limits the udp rate. a non-udp item needs no lookup.
// reset
//   arst_n clears control state, then a clearing pass walks the 2048 sets,
//   one set per cycle, zeroing valid bits and stamps; busy stays high
//   until it ends.
`default_nettype none

module flow_sequence_number_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] src_ip,
	input  wire logic [31:0] dst_ip,
	input  wire logic [15:0] sport,
	input  wire logic [15:0] dport,
	input  wire logic        is_udp,
	output logic             done,
	output logic             ok,
	output logic [31:0]      seq,
	output logic             new_flow
);

	// front to queue
	logic                   push;
	fsnt_pkg::item_t        push_item;
	// queue to back
	logic                   head_valid;
	fsnt_pkg::item_t        head_item;
	// back status for busy and credit return
	fsnt_pkg::back_status_t bstat;

	// intake and hashing
	fsnt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.src_ip    (src_ip),
		.dst_ip    (dst_ip),
		.sport     (sport),
		.dport     (dport),
		.is_udp    (is_udp),
		.bstat     (bstat),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue, never overflows thanks to the front's credits
	fsnt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (bstat.pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// table lookup, replacement and result
	fsnt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.bstat      (bstat),
		.done       (done),
		.ok         (ok),
		.seq        (seq),
		.new_flow   (new_flow)
	);

endmodule

`default_nettype wire
